// ===== rtl/crypto1_pkg.sv =====
package crypto1_pkg;

    // Command codes carried by the input transaction
    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_LOAD_KEY = 3'd1,
        CMD_BIT      = 3'd2,
        CMD_BYTE     = 3'd3,
        CMD_WORD_FWD = 3'd4,
        CMD_WORD_BWD = 3'd5
    } cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    localparam int HALF_W  = 24;
    localparam int KEY_W   = 48;
    localparam int WORD_W  = 32;

    // LFSR feedback taps of each half
    localparam logic [HALF_W-1:0] POLY_ODD  = 24'h29CE5C;
    localparam logic [HALF_W-1:0] POLY_EVEN = 24'h870804;

    // Nonlinear filter tables
    localparam logic [19:0] FILT_A   = 20'hf22c0;
    localparam logic [19:0] FILT_B   = 20'h6c9c0;
    localparam logic [19:0] FILT_C   = 20'h3c8b0;
    localparam logic [19:0] FILT_D   = 20'h1e458;
    localparam logic [19:0] FILT_E   = 20'h0d938;
    localparam logic [31:0] FILT_OUT = 32'hEC57E80A;

    // Last bit index of the forward modes
    localparam logic [4:0] LAST_BIT  = 5'd0;
    localparam logic [4:0] LAST_BYTE = 5'd7;
    localparam logic [4:0] LAST_WORD = 5'd31;
    // Byte swap of a word bit position
    localparam logic [4:0] WORD_SWAP = 5'd24;

    // Two-level filter of one half
    function automatic logic filt(input logic [HALF_W-1:0] x);
        logic [19:0] ta;
        logic [19:0] tb;
        logic [19:0] tc;
        logic [19:0] td;
        logic [19:0] te;
        logic [4:0]  idx;
        ta = FILT_A >> x[3:0];
        tb = FILT_B >> x[7:4];
        tc = FILT_C >> x[11:8];
        td = FILT_D >> x[15:12];
        te = FILT_E >> x[19:16];
        idx = {ta[4], tb[3], tc[2], td[1], te[0]};
        return FILT_OUT[idx];
    endfunction

    // Spread of the key over the odd half
    function automatic logic [HALF_W-1:0] key_odd(input logic [KEY_W-1:0] k);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int j = 0; j < HALF_W; j++)
        begin
            r[HALF_W-1-j] = k[(46 - 2*j) ^ 7];
        end
        return r;
    endfunction

    // Spread of the key over the even half
    function automatic logic [HALF_W-1:0] key_even(input logic [KEY_W-1:0] k);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int j = 0; j < HALF_W; j++)
        begin
            r[HALF_W-1-j] = k[(47 - 2*j) ^ 7];
        end
        return r;
    endfunction

endpackage

// ===== rtl/crypto1_if.sv =====
// Command channel
interface crypto1_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] data_in;
    logic        feed_keystream;

    modport source (output valid, output command, output data_in,
                    output feed_keystream, input ready);
    modport sink   (input valid, input command, input data_in,
                    input feed_keystream, output ready);
endinterface

// Keystream result channel
interface crypto1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] keystream;
    logic        next_filter_bit;

    modport source (output valid, output keystream, output next_filter_bit,
                    input ready);
    modport sink   (input valid, input keystream, input next_filter_bit,
                    output ready);
endinterface

// ===== rtl/crypto1_stream_cipher.sv =====
// Channel    Dir   Payload                                   Transaction when
// in_ch      in    command, data_in, feed_keystream          valid & ready
// out_ch     out   keystream, next_filter_bit                valid & ready
// cfg        in    cfg_wdata (48-bit key)                    cfg_we
//
// One LFSR step unit, forward or backward, runs one bit per cycle under a
// bit counter; a command runs 0, 1, 8 or 32 steps.
// in_ch.ready is high only while idle; the result sits in an output register,
// so the next command is taken while that result still waits on out_ch.
// A stalled output holds the sequencer in its finish state until taken.
// Reset clears the cipher state and the key.
module crypto1_stream_cipher (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [crypto1_pkg::KEY_W-1:0]    cfg_wdata,
    crypto1_in_if.sink                       in_ch,
    crypto1_out_if.source                    out_ch
);

    localparam int HW = crypto1_pkg::HALF_W;

    crypto1_pkg::state_t state_reg, state_next;

    logic [crypto1_pkg::KEY_W-1:0]  key_reg;
    logic [HW-1:0]                  odd_reg, odd_next;
    logic [HW-1:0]                  even_reg, even_next;
    logic [4:0]                     idx_reg, idx_next;
    logic [4:0]                     last_reg, last_next;
    logic                           back_reg, back_next;
    logic                           word_reg, word_next;
    logic                           fb_reg, fb_next;
    logic [31:0]                    data_reg, data_next;
    logic [31:0]                    ks_reg, ks_next;
    logic                           out_valid_reg, out_valid_next;
    logic [31:0]                    out_ks_reg, out_ks_next;
    logic                           out_nfb_reg, out_nfb_next;

    // Shared step unit
    logic [4:0]    pos;
    logic          din;
    logic          ks_fwd, ks_bwd, nb_fwd, nb_bwd, ks_bit, step_done;
    logic [HW-1:0] fwd_odd, fwd_even, bwd_odd, bwd_even;

    always_comb
    begin
        pos    = word_reg ? (idx_reg ^ crypto1_pkg::WORD_SWAP) : idx_reg;
        din    = data_reg[pos];
        // forward: filter of odd half, new bit enters the old even half
        ks_fwd = crypto1_pkg::filt(odd_reg);
        nb_fwd = (ks_fwd & fb_reg) ^ din
               ^ (^(crypto1_pkg::POLY_ODD & odd_reg))
               ^ (^(crypto1_pkg::POLY_EVEN & even_reg));
        fwd_even = odd_reg;
        fwd_odd  = {even_reg[HW-2:0], nb_fwd};
        // backward: halves swap, oldest bit recovered at the top
        ks_bwd = crypto1_pkg::filt(even_reg);
        nb_bwd = odd_reg[0]
               ^ (^(crypto1_pkg::POLY_EVEN & {1'b0, odd_reg[HW-1:1]}))
               ^ (^(crypto1_pkg::POLY_ODD & even_reg))
               ^ din ^ (ks_bwd & fb_reg);
        bwd_odd  = even_reg;
        bwd_even = {nb_bwd, odd_reg[HW-1:1]};
        ks_bit    = back_reg ? ks_bwd : ks_fwd;
        step_done = back_reg ? (idx_reg == 5'd0) : (idx_reg == last_reg);
    end

    // Sequencer and output register control
    always_comb
    begin
        state_next     = state_reg;
        odd_next       = odd_reg;
        even_next      = even_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        back_next      = back_reg;
        word_next      = word_reg;
        fb_next        = fb_reg;
        data_next      = data_reg;
        ks_next        = ks_reg;
        out_valid_next = out_valid_reg;
        out_ks_next    = out_ks_reg;
        out_nfb_next   = out_nfb_reg;
        in_ch.ready    = (state_reg == crypto1_pkg::ST_IDLE);

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            crypto1_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    data_next  = in_ch.data_in;
                    fb_next    = in_ch.feed_keystream;
                    ks_next    = '0;
                    back_next  = 1'b0;
                    word_next  = 1'b0;
                    idx_next   = 5'd0;
                    last_next  = crypto1_pkg::LAST_BIT;
                    state_next = crypto1_pkg::ST_FINISH;
                    case (in_ch.command)
                        crypto1_pkg::CMD_CLEAR:
                        begin
                            odd_next  = '0;
                            even_next = '0;
                        end
                        crypto1_pkg::CMD_LOAD_KEY:
                        begin
                            odd_next  = crypto1_pkg::key_odd(key_reg);
                            even_next = crypto1_pkg::key_even(key_reg);
                        end
                        crypto1_pkg::CMD_BIT:
                        begin
                            state_next = crypto1_pkg::ST_RUN;
                        end
                        crypto1_pkg::CMD_BYTE:
                        begin
                            last_next  = crypto1_pkg::LAST_BYTE;
                            state_next = crypto1_pkg::ST_RUN;
                        end
                        crypto1_pkg::CMD_WORD_FWD:
                        begin
                            last_next  = crypto1_pkg::LAST_WORD;
                            word_next  = 1'b1;
                            state_next = crypto1_pkg::ST_RUN;
                        end
                        crypto1_pkg::CMD_WORD_BWD:
                        begin
                            idx_next   = crypto1_pkg::LAST_WORD;
                            word_next  = 1'b1;
                            back_next  = 1'b1;
                            state_next = crypto1_pkg::ST_RUN;
                        end
                        default:
                        begin
                            // unused codes leave the cipher state alone
                        end
                    endcase
                end
            end
            crypto1_pkg::ST_RUN:
            begin
                // one LFSR step per cycle
                if (back_reg)
                begin
                    odd_next  = bwd_odd;
                    even_next = bwd_even;
                    idx_next  = idx_reg - 5'd1;
                end
                else
                begin
                    odd_next  = fwd_odd;
                    even_next = fwd_even;
                    idx_next  = idx_reg + 5'd1;
                end
                ks_next      = ks_reg;
                ks_next[pos] = ks_bit;
                if (step_done)
                begin
                    state_next = crypto1_pkg::ST_FINISH;
                end
            end
            crypto1_pkg::ST_FINISH:
            begin
                // hand off once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ks_next    = ks_reg;
                    out_nfb_next   = crypto1_pkg::filt(odd_reg);
                    state_next     = crypto1_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crypto1_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crypto1_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control, cipher state and key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg       <= '0;
            even_reg      <= '0;
            key_reg       <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= '0;
            back_reg      <= 1'b0;
            word_reg      <= 1'b0;
        end
        else
        begin
            odd_reg       <= odd_next;
            even_reg      <= even_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            back_reg      <= back_next;
            word_reg      <= word_next;
            if (cfg_we)
            begin
                key_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fb_reg      <= fb_next;
        data_reg    <= data_next;
        ks_reg      <= ks_next;
        out_ks_reg  <= out_ks_next;
        out_nfb_reg <= out_nfb_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.keystream       = out_ks_reg;
    assign out_ch.next_filter_bit = out_nfb_reg;

endmodule

// ===== rtl/crypto1_checker.sv =====
module crypto1_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] keystream,
    input logic        next_filter_bit
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(keystream)
                                    && $stable(next_filter_bit))
        else $error("stalled result changed");

    // busy right after a command is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready right after accept");

    // no result appears in the cycle after a command is taken
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(out_valid))
        else $error("result too early");

    // a word command keeps the block busy for its 32 steps
    a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (command == crypto1_pkg::CMD_WORD_FWD
                   || command == crypto1_pkg::CMD_WORD_BWD)
        |=> ##31 !in_ready)
        else $error("word command finished early");

endmodule

bind crypto1_stream_cipher crypto1_checker u_crypto1_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .command         (in_ch.command),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .keystream       (out_ch.keystream),
    .next_filter_bit (out_ch.next_filter_bit)
);
